// File: rtl/core/obi_pkg.sv
// Package for the occupancy box inflator: grid geometry, opcodes, config indexes.
// No dependencies.
package obi_pkg;
    localparam int GRID_S = 128;
    localparam int GRID_D = 64;
    localparam int GRID_T = 32;
    localparam int SW = $clog2(GRID_S);
    localparam int DW = $clog2(GRID_D);
    localparam int TW = $clog2(GRID_T);
    localparam int AW = SW + DW + TW;
    localparam int CELLS = GRID_S * GRID_D * GRID_T;

    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_CLEAR = 2'd1;
    localparam logic [1:0] OP_BUILD = 2'd2;

    localparam logic [2:0] CFG_STEP_SP = 3'd0;
    localparam logic [2:0] CFG_STEP_SN = 3'd1;
    localparam logic [2:0] CFG_STEP_DP = 3'd2;
    localparam logic [2:0] CFG_STEP_DN = 3'd3;
    localparam logic [2:0] CFG_STEP_TP = 3'd4;
    localparam logic [2:0] CFG_MAX_T   = 3'd5;

    typedef struct packed {
        logic           we;
        logic [AW-1:0]  waddr;
        logic           wdata;
        logic           re;
        logic [AW-1:0]  raddr;
    } grid_req_t;
endpackage

// File: rtl/core/obi_grid.sv
// Occupancy bit store, one write and one registered read per cycle.
// Depends on obi_pkg.
module obi_grid
    import obi_pkg::*;
(
    input  logic      clk,
    input  grid_req_t req,
    output logic      rdata
);
    logic mem [CELLS];

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        if (req.re)
        begin
            rdata <= mem[req.raddr];
        end
    end
endmodule

// File: rtl/core/occupancy_box_inflator_core.sv
// Top level of the occupancy box inflator: sequencer, config registers, grid.
// Depends on obi_pkg and obi_grid.
//
// Usage: pulse start with the item fields while busy is low. Write items
// pass through a write state, then the result state, before the done
// strobe; op-3 items go straight to the result state. A clear item sweeps
// the grid, one cell a cycle. A build item checks the seed box, then each
// tried plane, cell by cell, one grid read at a time through the read
// port; each cell takes a read state and a check state. busy is high while
// an item is in work. After reset a clearing pass over every cell runs
// with busy high; config writes are taken at any time (cfg_ready is always
// high). Results show on the box_* ports, held until the next result, with
// done high for one cycle; the receiver cannot stall, so nothing backs up.
module occupancy_box_inflator_core
    import obi_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  logic [1:0]    op,
    input  logic [6:0]    cell_s,
    input  logic [5:0]    cell_d,
    input  logic [4:0]    cell_t,
    input  logic          occupied,
    input  logic [6:0]    seed_b_s,
    input  logic [5:0]    seed_b_d,
    input  logic [4:0]    seed_b_t,
    input  logic [6:0]    s_upper_limit,
    input  logic [6:0]    s_lower_limit,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [2:0]    cfg_index,
    input  logic [6:0]    cfg_data,
    output logic          done,
    output logic          box_ok,
    output logic [6:0]    box_s_low,
    output logic [6:0]    box_s_high,
    output logic [5:0]    box_d_low,
    output logic [5:0]    box_d_high,
    output logic [4:0]    box_t_low,
    output logic [4:0]    box_t_high
);
    typedef enum logic [8:0] {
        ST_CLEAR = 9'b000000001,
        ST_IDLE  = 9'b000000010,
        ST_RD    = 9'b000000100,
        ST_CHK   = 9'b000001000,
        ST_PLANE = 9'b000010000,
        ST_SIDE  = 9'b000100000,
        ST_RES   = 9'b001000000,
        ST_WR    = 9'b010000000,
        ST_SEED  = 9'b100000000
    } state_t;

    // phases: seed box check, then plane tries
    state_t state_reg, state_next;

    logic [6:0] stp_sp_reg, stp_sn_reg, stp_tp_lo;
    logic [5:0] stp_dp_reg, stp_dn_reg;
    logic [4:0] stp_tp_reg, maxt_reg;

    logic [SW-1:0] slo_reg, shi_reg, slim_hi_reg, slim_lo_reg;
    logic [DW-1:0] dlo_reg, dhi_reg;
    logic [TW-1:0] tlo_reg, thi_reg;
    logic [SW-1:0] cs_reg;
    logic [DW-1:0] cd_reg;
    logic [TW-1:0] ct_reg;
    logic [AW:0]   clr_reg;
    logic          ok_reg, seed_reg;
    logic [2:0]    side_reg;     // 0 sp,1 sn,2 dp,3 dn,4 tp
    logic [4:0]    fin_reg;      // finished flags sp sn dp dn tp
    logic [6:0]    cnt_reg;      // planes grown this side this round
    logic [SW-1:0] pls_lo, pls_hi;
    logic [DW-1:0] pld_lo, pld_hi;
    logic [TW-1:0] plt_lo, plt_hi;
    logic          edge_hit;
    logic [6:0]    side_step;
    logic [SW-1:0] sd_slo, sd_shi;
    logic [DW-1:0] sd_dlo, sd_dhi;
    logic [TW-1:0] sd_tlo, sd_thi;

    grid_req_t req;
    logic      rdata;

    obi_grid u_grid (.clk(clk), .req(req), .rdata(rdata));

    assign cfg_ready = 1'b1;
    assign busy = (state_reg != ST_IDLE);
    assign stp_tp_lo = {2'b0, stp_tp_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stp_sp_reg <= 7'd1;
            stp_sn_reg <= 7'd1;
            stp_dp_reg <= 6'd1;
            stp_dn_reg <= 6'd1;
            stp_tp_reg <= 5'd1;
            maxt_reg   <= 5'd31;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_STEP_SP: stp_sp_reg <= cfg_data;
                CFG_STEP_SN: stp_sn_reg <= cfg_data;
                CFG_STEP_DP: stp_dp_reg <= cfg_data[5:0];
                CFG_STEP_DN: stp_dn_reg <= cfg_data[5:0];
                CFG_STEP_TP: stp_tp_reg <= cfg_data[4:0];
                CFG_MAX_T:   maxt_reg   <= cfg_data[4:0];
                default: ;
            endcase
        end
    end

    // seed bounding box of a build word, zero box otherwise
    always_comb
    begin
        sd_slo = '0; sd_shi = '0;
        sd_dlo = '0; sd_dhi = '0;
        sd_tlo = '0; sd_thi = '0;
        if (op == OP_BUILD)
        begin
            sd_slo = (cell_s < seed_b_s) ? cell_s : seed_b_s;
            sd_shi = (cell_s < seed_b_s) ? seed_b_s : cell_s;
            sd_dlo = (cell_d < seed_b_d) ? cell_d : seed_b_d;
            sd_dhi = (cell_d < seed_b_d) ? seed_b_d : cell_d;
            sd_tlo = (cell_t < seed_b_t) ? cell_t : seed_b_t;
            sd_thi = (cell_t < seed_b_t) ? seed_b_t : cell_t;
        end
    end

    // plane of the side under test (one cell beyond the box)
    always_comb
    begin
        pls_lo = slo_reg; pls_hi = shi_reg;
        pld_lo = dlo_reg; pld_hi = dhi_reg;
        plt_lo = tlo_reg; plt_hi = thi_reg;
        edge_hit = 1'b0;
        side_step = 7'd1;
        case (side_reg)
            3'd0:
            begin
                edge_hit = (shi_reg == SW'(GRID_S - 1));
                pls_lo = shi_reg + 1'b1; pls_hi = shi_reg + 1'b1;
                side_step = stp_sp_reg;
            end
            3'd1:
            begin
                edge_hit = (slo_reg == '0);
                pls_lo = slo_reg - 1'b1; pls_hi = slo_reg - 1'b1;
                side_step = stp_sn_reg;
            end
            3'd2:
            begin
                edge_hit = (dhi_reg == DW'(GRID_D - 1));
                pld_lo = dhi_reg + 1'b1; pld_hi = dhi_reg + 1'b1;
                side_step = {1'b0, stp_dp_reg};
            end
            3'd3:
            begin
                edge_hit = (dlo_reg == '0);
                pld_lo = dlo_reg - 1'b1; pld_hi = dlo_reg - 1'b1;
                side_step = {1'b0, stp_dn_reg};
            end
            default:
            begin
                edge_hit = (thi_reg == TW'(GRID_T - 1));
                plt_lo = thi_reg + 1'b1; plt_hi = thi_reg + 1'b1;
                side_step = stp_tp_lo;
            end
        endcase
        if (side_step == '0)
        begin
            side_step = 7'd1;
        end
    end

    logic [SW-1:0] ws_hi;
    logic [DW-1:0] wd_lo, wd_hi;
    logic [TW-1:0] wt_lo, wt_hi;
    logic          last_cell;
    always_comb
    begin
        if (seed_reg)
        begin
            ws_hi = shi_reg; wd_lo = dlo_reg;
            wd_hi = dhi_reg; wt_lo = tlo_reg; wt_hi = thi_reg;
        end
        else
        begin
            ws_hi = pls_hi; wd_lo = pld_lo;
            wd_hi = pld_hi; wt_lo = plt_lo; wt_hi = plt_hi;
        end
        last_cell = (cs_reg == ws_hi) && (cd_reg == wd_hi) && (ct_reg == wt_hi);
    end

    always_comb
    begin
        req.we = 1'b0;
        req.waddr = {cs_reg, cd_reg, ct_reg};
        req.wdata = 1'b0;
        req.re = (state_reg == ST_RD);
        req.raddr = {cs_reg, cd_reg, ct_reg};
        if (state_reg == ST_CLEAR)
        begin
            req.we = 1'b1;
            req.waddr = clr_reg[AW-1:0];
        end
        else if (state_reg == ST_WR)
        begin
            req.we = 1'b1;
            req.wdata = ok_reg;
        end
    end

    logic [4:0] fin_round;
    logic [TW:0] tspan;
    assign tspan = {1'b0, thi_reg} - {1'b0, tlo_reg};

    // s limits are checked once per round
    always_comb
    begin
        fin_round = fin_reg;
        if (shi_reg >= slim_hi_reg) fin_round[0] = 1'b1;
        if (slo_reg <= slim_lo_reg) fin_round[1] = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            clr_reg     <= '0;
            done        <= 1'b0;
            ok_reg      <= 1'b0;
            seed_reg    <= 1'b0;
            slo_reg     <= '0;
            shi_reg     <= '0;
            dlo_reg     <= '0;
            dhi_reg     <= '0;
            tlo_reg     <= '0;
            thi_reg     <= '0;
            cs_reg      <= '0;
            cd_reg      <= '0;
            ct_reg      <= '0;
            slim_hi_reg <= '0;
            slim_lo_reg <= '0;
            fin_reg     <= '0;
            side_reg    <= 3'd0;
            cnt_reg     <= '0;
            box_ok      <= 1'b0;
            box_s_low   <= '0;
            box_s_high  <= '0;
            box_d_low   <= '0;
            box_d_high  <= '0;
            box_t_low   <= '0;
            box_t_high  <= '0;
        end
        else
        begin
            done <= (state_reg == ST_RES);
            case (state_reg)
                ST_CLEAR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg[AW-1:0] == AW'(CELLS - 1))
                    begin
                        state_reg <= (seed_reg) ? ST_RES : ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    if (start)
                    begin
                        ok_reg <= (op == OP_WRITE) ? occupied : 1'b0;
                        seed_reg <= (op == OP_CLEAR) || (op == OP_BUILD);
                        slo_reg <= sd_slo; shi_reg <= sd_shi; dlo_reg <= sd_dlo;
                        dhi_reg <= sd_dhi; tlo_reg <= sd_tlo; thi_reg <= sd_thi;
                        cs_reg <= cell_s; cd_reg <= cell_d; ct_reg <= cell_t;
                        slim_hi_reg <= s_upper_limit;
                        slim_lo_reg <= s_lower_limit;
                        case (op)
                            OP_WRITE: state_reg <= ST_WR;
                            OP_CLEAR:
                            begin
                                clr_reg <= '0;
                                state_reg <= ST_CLEAR;
                            end
                            OP_BUILD: state_reg <= ST_SEED;
                            default: state_reg <= ST_RES;
                        endcase
                    end
                end
                ST_WR:
                begin
                    ok_reg <= 1'b0;
                    state_reg <= ST_RES;
                end
                ST_SEED:
                begin
                    cs_reg <= slo_reg; cd_reg <= dlo_reg; ct_reg <= tlo_reg;
                    state_reg <= ST_RD;
                end
                ST_RD:
                begin
                    state_reg <= ST_CHK;
                end
                ST_CHK:
                begin
                    if (rdata)
                    begin
                        if (seed_reg)
                        begin
                            state_reg <= ST_RES;
                        end
                        else
                        begin
                            fin_reg[side_reg] <= 1'b1;
                            state_reg <= ST_SIDE;
                        end
                    end
                    else if (last_cell)
                    begin
                        if (seed_reg)
                        begin
                            seed_reg <= 1'b0;
                            ok_reg <= 1'b1;
                            fin_reg <= '0;
                            side_reg <= 3'd0;
                            cnt_reg <= '0;
                            state_reg <= ST_PLANE;
                        end
                        else
                        begin
                            case (side_reg)
                                3'd0: shi_reg <= pls_hi;
                                3'd1: slo_reg <= pls_lo;
                                3'd2: dhi_reg <= pld_hi;
                                3'd3: dlo_reg <= pld_lo;
                                default: thi_reg <= plt_hi;
                            endcase
                            cnt_reg <= cnt_reg + 1'b1;
                            if (cnt_reg + 1'b1 == side_step)
                            begin
                                state_reg <= ST_SIDE;
                            end
                            else
                            begin
                                state_reg <= ST_PLANE;
                            end
                        end
                    end
                    else
                    begin
                        state_reg <= ST_RD;
                        if (ct_reg != wt_hi)
                        begin
                            ct_reg <= ct_reg + 1'b1;
                        end
                        else
                        begin
                            ct_reg <= wt_lo;
                            if (cd_reg != wd_hi)
                            begin
                                cd_reg <= cd_reg + 1'b1;
                            end
                            else
                            begin
                                cd_reg <= wd_lo;
                                cs_reg <= cs_reg + 1'b1;
                            end
                        end
                    end
                end
                ST_PLANE:
                begin
                    // start a plane try for the current side, or skip it if finished or at the grid edge
                    if (fin_reg[side_reg])
                    begin
                        state_reg <= ST_SIDE;
                    end
                    else if (edge_hit)
                    begin
                        fin_reg[side_reg] <= 1'b1;
                        state_reg <= ST_SIDE;
                    end
                    else
                    begin
                        cs_reg <= pls_lo; cd_reg <= pld_lo; ct_reg <= plt_lo;
                        state_reg <= ST_RD;
                    end
                end
                ST_SIDE:
                begin
                    cnt_reg <= '0;
                    if (side_reg == 3'd4)
                    begin
                        if (fin_reg[4] || tspan >= {1'b0, maxt_reg})
                        begin
                            state_reg <= ST_RES;
                        end
                        else
                        begin
                            state_reg <= ST_PLANE;
                        end
                    end
                    else if (side_reg == 3'd3)
                    begin
                        state_reg <= ST_PLANE;
                        fin_reg <= fin_round;
                        side_reg <= (&fin_round[3:0]) ? 3'd4 : 3'd0;
                    end
                    else
                    begin
                        state_reg <= ST_PLANE;
                        side_reg <= side_reg + 1'b1;
                    end
                end
                ST_RES:
                begin
                    box_ok <= ok_reg;
                    box_s_low <= slo_reg; box_s_high <= shi_reg;
                    box_d_low <= dlo_reg; box_d_high <= dhi_reg;
                    box_t_low <= tlo_reg; box_t_high <= thi_reg;
                    seed_reg <= 1'b0;
                    state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end
endmodule

// File: bench/occupancy_box_inflator_core_test.sv
// Self-checking bench for occupancy_box_inflator_core: drives cell writes, grid clears
// and box builds, predicts every box from a local copy of grid and config.
// Depends on obi_pkg and the occupancy_box_inflator_core RTL.
`timescale 1ns / 100ps

module occupancy_box_inflator_core_test;
    import obi_pkg::*;

    localparam logic [1:0] OP_NONE = 2'd3;
    localparam int WATCHDOG_LIMIT = 2000000;

    typedef struct packed {
        logic [1:0] op;
        logic [6:0] cs;
        logic [5:0] cd;
        logic [4:0] ct;
        logic       occ;
        logic [6:0] bs;
        logic [5:0] bd;
        logic [4:0] bt;
        logic [6:0] su;
        logic [6:0] sl;
    } cmd_t;

    typedef struct packed {
        logic       ok;
        logic [6:0] s_lo;
        logic [6:0] s_hi;
        logic [5:0] d_lo;
        logic [5:0] d_hi;
        logic [4:0] t_lo;
        logic [4:0] t_hi;
    } box_t;

    logic       clk;
    logic       rst_n;
    logic       start;
    logic       busy;
    logic [1:0] op;
    logic [6:0] cell_s;
    logic [5:0] cell_d;
    logic [4:0] cell_t;
    logic       occupied;
    logic [6:0] seed_b_s;
    logic [5:0] seed_b_d;
    logic [4:0] seed_b_t;
    logic [6:0] s_upper_limit;
    logic [6:0] s_lower_limit;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [2:0] cfg_index;
    logic [6:0] cfg_data;
    logic       done;
    logic       box_ok;
    logic [6:0] box_s_low;
    logic [6:0] box_s_high;
    logic [5:0] box_d_low;
    logic [5:0] box_d_high;
    logic [4:0] box_t_low;
    logic [4:0] box_t_high;

    occupancy_box_inflator_core dut (.*);

    bit   occ_grid [0:CELLS-1];
    int   step_cfg [6];
    int   lo_b [3];
    int   hi_b [3];
    int   axis_len [3] = '{GRID_S, GRID_D, GRID_T};
    box_t pending_boxes [$];
    box_t want;
    bit   idle_on;
    int   mismatches;
    int   idle_cycles;
    int   n_words;
    int   n_builds;
    int   n_grown;
    int   n_clears;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic bit cell_taken(int s, int d, int t);
        if (s < 0 || s >= GRID_S || d < 0 || d >= GRID_D || t < 0 || t >= GRID_T)
            return 1'b1;
        return occ_grid[(s * GRID_D + d) * GRID_T + t];
    endfunction

    function automatic bit region_clear(input int l[3], input int h[3]);
        for (int s = l[0]; s <= h[0]; s++)
            for (int d = l[1]; d <= h[1]; d++)
                for (int t = l[2]; t <= h[2]; t++)
                    if (cell_taken(s, d, t))
                        return 1'b0;
        return 1'b1;
    endfunction

    // Push one face outward by up to steps planes; 1 means this face is done.
    function automatic bit push_face(int ax, bit up, int steps);
        int pl [3];
        int ph [3];
        int nxt;
        for (int i = 0; i < steps; i++)
        begin
            nxt = up ? hi_b[ax] + 1 : lo_b[ax] - 1;
            if (nxt < 0 || nxt >= axis_len[ax])
                return 1'b1;
            pl = lo_b;
            ph = hi_b;
            pl[ax] = nxt;
            ph[ax] = nxt;
            if (!region_clear(pl, ph))
                return 1'b1;
            if (up)
                hi_b[ax] = nxt;
            else
                lo_b[ax] = nxt;
        end
        return 1'b0;
    endfunction

    function automatic int step_of(int k);
        return step_cfg[k] == 0 ? 1 : step_cfg[k];
    endfunction

    function automatic int cfg_mask(int k);
        return k < 2 ? 'h7f : (k < 4 ? 'h3f : 'h1f);
    endfunction

    function automatic box_t predict_box(cmd_t c);
        box_t r;
        int   a [3];
        int   b [3];
        bit   sp, sn, dp, dn, tp;
        r = '0;
        case (c.op)
            OP_WRITE: occ_grid[{c.cs, c.cd, c.ct}] = c.occ;
            OP_CLEAR: foreach (occ_grid[i]) occ_grid[i] = 1'b0;
            OP_BUILD:
            begin
                a = '{int'(c.cs), int'(c.cd), int'(c.ct)};
                b = '{int'(c.bs), int'(c.bd), int'(c.bt)};
                for (int k = 0; k < 3; k++)
                begin
                    lo_b[k] = a[k] < b[k] ? a[k] : b[k];
                    hi_b[k] = a[k] < b[k] ? b[k] : a[k];
                end
                if (region_clear(lo_b, hi_b))
                begin
                    r.ok = 1'b1;
                    {sp, sn, dp, dn, tp} = '0;
                    while (!(sp && sn && dp && dn))
                    begin
                        if (!sp) sp = push_face(0, 1'b1, step_of(0));
                        if (!sn) sn = push_face(0, 1'b0, step_of(1));
                        if (!dp) dp = push_face(1, 1'b1, step_of(2));
                        if (!dn) dn = push_face(1, 1'b0, step_of(3));
                        if (hi_b[0] >= int'(c.su)) sp = 1'b1;
                        if (lo_b[0] <= int'(c.sl)) sn = 1'b1;
                    end
                    while (!tp)
                    begin
                        tp = push_face(2, 1'b1, step_of(4));
                        if (hi_b[2] - lo_b[2] >= step_cfg[5])
                            tp = 1'b1;
                    end
                end
                r.s_lo = 7'(lo_b[0]);
                r.s_hi = 7'(hi_b[0]);
                r.d_lo = 6'(lo_b[1]);
                r.d_hi = 6'(hi_b[1]);
                r.t_lo = 5'(lo_b[2]);
                r.t_hi = 5'(hi_b[2]);
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int exp);
        $display("mismatch: %s got %0d want %0d at %0t", what, got, exp, $realtime);
        mismatches++;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_boxes.size() == 0)
                report_mismatch("result with nothing pending", box_ok, 0);
            else
            begin
                want = pending_boxes.pop_front();
                if (box_ok !== want.ok) report_mismatch("box_ok", box_ok, want.ok);
                if (box_s_low !== want.s_lo) report_mismatch("box_s_low", box_s_low, want.s_lo);
                if (box_s_high !== want.s_hi) report_mismatch("box_s_high", box_s_high, want.s_hi);
                if (box_d_low !== want.d_lo) report_mismatch("box_d_low", box_d_low, want.d_lo);
                if (box_d_high !== want.d_hi) report_mismatch("box_d_high", box_d_high, want.d_hi);
                if (box_t_low !== want.t_lo) report_mismatch("box_t_low", box_t_low, want.t_lo);
                if (box_t_high !== want.t_hi) report_mismatch("box_t_high", box_t_high, want.t_hi);
                if (want.ok)
                    n_grown++;
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done || (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAIL occupancy_box_inflator_core");
            $finish;
        end
    end

    task automatic send_item(cmd_t c);
        int gap;
        @(negedge clk);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            start = 1'b0;
            gap = $urandom_range(1, 9);
            repeat (gap) @(negedge clk);
        end
        op = c.op;
        cell_s = c.cs;
        cell_d = c.cd;
        cell_t = c.ct;
        occupied = c.occ;
        seed_b_s = c.bs;
        seed_b_d = c.bd;
        seed_b_t = c.bt;
        s_upper_limit = c.su;
        s_lower_limit = c.sl;
        start = 1'b1;
        do @(posedge clk); while (busy);
        pending_boxes = {pending_boxes, predict_box(c)};
        n_words++;
        if (c.op == OP_BUILD) n_builds++;
        if (c.op == OP_CLEAR) n_clears++;
    endtask

    task automatic pause_until_idle();
        @(negedge clk);
        start = 1'b0;
        while (pending_boxes.size() != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, int data);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = 7'(data);
        do @(posedge clk); while (!cfg_ready);
        step_cfg[idx] = data & 'h7f & cfg_mask(idx);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic set_steps(int sp, int sn, int dp, int dn, int tp, int mt);
        pause_until_idle();
        write_reg(CFG_STEP_SP, sp);
        write_reg(CFG_STEP_SN, sn);
        write_reg(CFG_STEP_DP, dp);
        write_reg(CFG_STEP_DN, dn);
        write_reg(CFG_STEP_TP, tp);
        write_reg(CFG_MAX_T, mt);
    endtask

    task automatic write_at(int s, int d, int t, bit v);
        cmd_t c;
        if (s < 0 || s >= GRID_S || d < 0 || d >= GRID_D || t < 0 || t >= GRID_T)
            return;
        c = '0;
        c.op = OP_WRITE;
        c.cs = 7'(s);
        c.cd = 6'(d);
        c.ct = 5'(t);
        c.occ = v;
        send_item(c);
    endtask

    task automatic build_at(int as, int ad, int at, int bs, int bd, int bt, int su, int sl);
        cmd_t c;
        c = '0;
        c.op = OP_BUILD;
        c.cs = 7'(as);
        c.cd = 6'(ad);
        c.ct = 5'(at);
        c.bs = 7'(bs);
        c.bd = 6'(bd);
        c.bt = 5'(bt);
        c.su = 7'(su);
        c.sl = 7'(sl);
        send_item(c);
    endtask

    task automatic send_plain(logic [1:0] code);
        cmd_t       c;
        logic [63:0] rv;
        rv = {$urandom, $urandom};
        c = rv[$bits(cmd_t)-1:0];
        c.op = code;
        send_item(c);
    endtask

    // Occupied cells around the seeds bound the growth; one face may be left open.
    task automatic caged_build(bit may_open);
        int cs, cd, ct, bs, bd, bt, shi, slo, dhi, dlo, thi, su, sl, gap_face;
        cs = $urandom_range(0, GRID_S - 1);
        cd = $urandom_range(0, GRID_D - 1);
        ct = $urandom_range(0, GRID_T - 1);
        bs = (cs < GRID_S - 1 && $urandom_range(0, 1)) ? cs + 1 : cs;
        bd = (cd < GRID_D - 1 && $urandom_range(0, 1)) ? cd + 1 : cd;
        bt = (ct < GRID_T - 1 && $urandom_range(0, 1)) ? ct + 1 : ct;
        shi = bs;
        slo = cs;
        dhi = bd;
        dlo = cd;
        thi = bt;
        gap_face = (may_open && $urandom_range(0, 3) == 0) ? $urandom_range(0, 4) : 5;
        if (gap_face != 0) write_at(shi + $urandom_range(1, 6), cd, ct, 1'b1);
        if (gap_face != 1) write_at(slo - $urandom_range(1, 6), cd, ct, 1'b1);
        if (gap_face != 2) write_at(cs, dhi + $urandom_range(1, 6), ct, 1'b1);
        if (gap_face != 3) write_at(cs, dlo - $urandom_range(1, 6), ct, 1'b1);
        if (gap_face != 4) write_at(cs, cd, thi + $urandom_range(1, 6), 1'b1);
        if ($urandom_range(0, 9) == 0)
            write_at(bs, bd, bt, 1'b1);
        if ($urandom_range(0, 4) == 0)
        begin
            su = $urandom_range(0, shi);
            sl = $urandom_range(slo, GRID_S - 1);
        end
        else
        begin
            su = shi + $urandom_range(0, 3);
            sl = slo - $urandom_range(0, 3);
            if (su > GRID_S - 1) su = GRID_S - 1;
            if (sl < 0) sl = 0;
        end
        if ($urandom_range(0, 1))
            build_at(cs, cd, ct, bs, bd, bt, su, sl);
        else
            build_at(bs, bd, bt, cs, cd, ct, su, sl);
    endtask

    task automatic random_mix(int groups, bit may_open);
        int r;
        repeat (groups)
        begin
            r = $urandom_range(0, 99);
            if (r < 60)
                caged_build(may_open);
            else if (r < 85)
                send_plain(OP_WRITE);
            else
                send_plain(OP_NONE);
        end
    endtask

    task automatic test_cell_writes();
        write_at(GRID_S - 1, GRID_D - 1, GRID_T - 1, 1'b1);
        write_at(0, 0, 0, 1'b1);
        write_at(5, 5, 5, 1'b1);
        write_at(5, 5, 5, 1'b0);
        send_plain(OP_NONE);
    endtask

    task automatic test_blocked_seeds();
        build_at(0, 0, 0, 1, 1, 1, 0, 0);
        build_at(127, 63, 31, 126, 62, 30, 127, 127);
        build_at(4, 4, 4, 6, 6, 6, 6, 4);
    endtask

    task automatic test_grid_clear();
        pause_until_idle();
        send_plain(OP_CLEAR);
        build_at(0, 0, 0, 0, 0, 0, 0, 0);
        build_at(127, 63, 31, 127, 63, 31, 127, 127);
    endtask

    task automatic test_config_extremes();
        set_steps(0, 0, 0, 0, 0, 0);
        caged_build(1'b0);
        caged_build(1'b0);
        set_steps(127, 127, 127, 127, 127, 127);
        caged_build(1'b0);
        caged_build(1'b0);
        set_steps(64, 64, 64, 64, 96, 32);
        caged_build(1'b0);
    endtask

    task automatic test_random_phases();
        set_steps(1, 1, 1, 1, 1, 2);
        random_mix(150, 1'b1);
        pause_until_idle();
        send_plain(OP_CLEAR);
        set_steps($urandom_range(2, 8), $urandom_range(2, 8), $urandom_range(2, 8),
                  $urandom_range(2, 8), $urandom_range(2, 8), $urandom_range(1, 4));
        random_mix(160, 1'b1);
        set_steps(0, 0, 0, 0, 0, 0);
        random_mix(110, 1'b1);
    endtask

    task automatic test_unthrottled_tail();
        set_steps(127, 127, 63, 63, 31, 31);
        idle_on = 1'b0;
        random_mix(90, 1'b0);
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        op = OP_WRITE;
        {cell_s, cell_d, cell_t, occupied} = '0;
        {seed_b_s, seed_b_d, seed_b_t, s_upper_limit, s_lower_limit} = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_STEP_SP;
        cfg_data = '0;
        step_cfg = '{1, 1, 1, 1, 1, 31};
        idle_on = 1'b1;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        test_cell_writes();
        test_blocked_seeds();
        test_grid_clear();
        test_config_extremes();
        test_random_phases();
        test_unthrottled_tail();
        pause_until_idle();
        repeat (20) @(negedge clk);
        $display("covered %0d words: %0d builds (%0d grown), %0d grid clears",
                 n_words, n_builds, n_grown, n_clears);
        if (mismatches == 0)
            $display("PASS occupancy_box_inflator_core");
        else
            $display("FAIL occupancy_box_inflator_core");
        $finish;
    end
endmodule
